/* sv/tdsp_pkg.sv */
// ----------------------------------------------------------------------------
// tdsp_pkg
// Shared types, constants and helper functions for the tank drive smoothing
// and servo pulse block.
// ----------------------------------------------------------------------------
package tdsp_pkg;

  // field and datapath widths
  localparam int LVL_W   = 16;              // Q1.14 level and target width
  localparam int ACC_W   = 19;              // serial multiplier accumulator width
  localparam int MPL_W   = 16;              // multiplier digits per pass
  localparam int CNT_W   = $clog2(MPL_W);
  localparam int Q_W     = 11;              // scaled pulse offset width
  localparam int PULSE_W = 11;
  localparam int PSUM_W  = 13;              // signed pulse sum width
  localparam int SPAN_W  = 10;
  localparam int TRIM_W  = 9;
  localparam int ALPHA_W = 16;
  localparam int CIDX_W  = 3;
  localparam int CDAT_W  = 16;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MPL_W - 1);

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_DRIVE_ALPHA = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_DOME_ALPHA  = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_DRIVE_SPAN  = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_DOME_SPAN   = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_LEFT_TRIM   = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_RIGHT_TRIM  = 3'd5;

  // configuration reset values
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd6554;
  localparam logic [SPAN_W-1:0]  SPAN_RST  = 10'd400;

  // Q1.14 full scale and thresholds (0.05 and 0.02 of full scale)
  localparam logic signed [17:0]  ONE_Q14_S     = 18'sd16384;
  localparam logic signed [17:0]  NEG_ONE_Q14_S = -18'sd16384;
  localparam logic [ACC_W-1:0]    DRIVE_SNAP_MAX = 19'd819;
  localparam logic [ACC_W-1:0]    DOME_SNAP_MAX  = 19'd327;
  localparam logic [ACC_W-1:0]    WAKE_MIN       = 19'd820;

  // pulse limits
  localparam logic signed [PSUM_W-1:0] PULSE_CENTER_S = 13'sd1500;
  localparam logic signed [PSUM_W-1:0] PULSE_MIN_S    = 13'sd1000;
  localparam logic signed [PSUM_W-1:0] PULSE_MAX_S    = 13'sd2000;
  localparam logic [PULSE_W-1:0]       PULSE_CENTER   = 11'd1500;
  localparam logic [PULSE_W-1:0]       PULSE_MIN      = 11'd1000;
  localparam logic [PULSE_W-1:0]       PULSE_MAX      = 11'd2000;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SMOOTH,
    ST_SETTLE,
    ST_SCALE,
    ST_FINISH
  } state_t;

  // control of one serial multiply lane
  typedef struct packed {
    logic load;
    logic step;
    logic rnd;
  } lane_ctrl_t;

  // sequencer strobes toward the datapath
  typedef struct packed {
    logic       accept;
    logic       settle;
    logic       finish;
    lane_ctrl_t lane;
  } ctl_t;

  // saturate a mixed command to +/-1.0
  function automatic logic signed [LVL_W-1:0] sat_q14(input logic signed [17:0] v);
    logic signed [17:0] c;
    begin
      if (v > ONE_Q14_S) c = ONE_Q14_S;
      else if (v < NEG_ONE_Q14_S) c = NEG_ONE_Q14_S;
      else c = v;
      sat_q14 = c[LVL_W-1:0];
    end
  endfunction

  // magnitude of an accumulator-wide value
  function automatic logic [ACC_W-1:0] mag19(input logic signed [ACC_W-1:0] v);
    begin
      mag19 = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    end
  endfunction

  // sign extend a level to accumulator width
  function automatic logic signed [ACC_W-1:0] ext19(input logic signed [LVL_W-1:0] v);
    begin
      ext19 = {{(ACC_W-LVL_W){v[LVL_W-1]}}, v};
    end
  endfunction

  // center plus trim plus or minus offset, clamped to the servo range
  function automatic logic [PULSE_W-1:0] pulse_calc(input logic signed [TRIM_W-1:0] trim,
                                                    input logic [Q_W-1:0] q,
                                                    input logic neg);
    logic signed [PSUM_W-1:0] s;
    logic signed [PSUM_W-1:0] qs;
    logic signed [PSUM_W-1:0] ts;
    begin
      qs = {{(PSUM_W-Q_W){1'b0}}, q};
      ts = {{(PSUM_W-TRIM_W){trim[TRIM_W-1]}}, trim};
      s  = neg ? (PULSE_CENTER_S + ts - qs) : (PULSE_CENTER_S + ts + qs);
      if (s < PULSE_MIN_S) s = PULSE_MIN_S;
      else if (s > PULSE_MAX_S) s = PULSE_MAX_S;
      pulse_calc = s[PULSE_W-1:0];
    end
  endfunction

endpackage

/* sv/tdsp_mac_lane.sv */
// ----------------------------------------------------------------------------
// tdsp_mac_lane
// Bit-serial signed by unsigned multiplier. The multiplier word is consumed
// one bit per cycle while step is set, LSB first; the accumulator shifts right
// each step so the result after a full pass is floor(op * mpl / 2^MPL_W), with
// an optional rounding carry injected on a chosen step.
// ----------------------------------------------------------------------------
module tdsp_mac_lane (
  input  logic                                clk,
  input  tdsp_pkg::lane_ctrl_t                ctl,
  input  logic signed [tdsp_pkg::ACC_W-1:0]   op_in,
  input  logic [tdsp_pkg::MPL_W-1:0]          mpl_in,
  output logic signed [tdsp_pkg::ACC_W-1:0]   acc_out
);

  logic signed [tdsp_pkg::ACC_W-1:0] op_r;
  logic [tdsp_pkg::MPL_W-1:0]        mpl_r, mpl_nxt;
  logic signed [tdsp_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [tdsp_pkg::ACC_W-1:0]        addend;
  logic [tdsp_pkg::ACC_W-1:0]        sum;

  // one shift-add step
  always_comb begin
    addend  = mpl_r[0] ? op_r : '0;
    sum     = acc_r + addend + {{(tdsp_pkg::ACC_W-1){1'b0}}, ctl.rnd};
    acc_nxt = {sum[tdsp_pkg::ACC_W-1], sum[tdsp_pkg::ACC_W-1:1]};
    mpl_nxt = {1'b0, mpl_r[tdsp_pkg::MPL_W-1:1]};
  end

  // operand, multiplier shift register and accumulator
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_r  <= op_in;
      mpl_r <= mpl_in;
      acc_r <= '0;
    end else if (ctl.step) begin
      mpl_r <= mpl_nxt;
      acc_r <= acc_nxt;
    end
  end

  assign acc_out = acc_r;

endmodule

/* sv/tdsp_ctrl.sv */
// ----------------------------------------------------------------------------
// tdsp_ctrl
// Sequencer: accept, serial smoothing pass, settle, serial scaling pass,
// then hand the result to the output register.
// ----------------------------------------------------------------------------
module tdsp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           out_busy,
  output logic           in_stall,
  output tdsp_pkg::ctl_t ctl
);

  tdsp_pkg::state_t              state_r, state_nxt;
  logic [tdsp_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;

  // state and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdsp_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      tdsp_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) state_nxt = tdsp_pkg::ST_SMOOTH;
      end
      tdsp_pkg::ST_SMOOTH: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == tdsp_pkg::CNT_LAST) state_nxt = tdsp_pkg::ST_SETTLE;
      end
      tdsp_pkg::ST_SETTLE: begin
        cnt_nxt   = '0;
        state_nxt = tdsp_pkg::ST_SCALE;
      end
      tdsp_pkg::ST_SCALE: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == tdsp_pkg::CNT_LAST) state_nxt = tdsp_pkg::ST_FINISH;
      end
      tdsp_pkg::ST_FINISH: begin
        if (!out_busy) state_nxt = tdsp_pkg::ST_IDLE;
      end
      default: state_nxt = tdsp_pkg::ST_IDLE;
    endcase
  end

  // strobes
  always_comb begin
    ctl      = '0;
    in_stall = 1'b1;
    case (state_r)
      tdsp_pkg::ST_IDLE: begin
        in_stall      = 1'b0;
        ctl.accept    = in_valid;
        ctl.lane.load = in_valid;
      end
      tdsp_pkg::ST_SMOOTH: begin
        ctl.lane.step = 1'b1;
        ctl.lane.rnd  = (cnt_r == tdsp_pkg::CNT_LAST);
      end
      tdsp_pkg::ST_SETTLE: begin
        ctl.settle    = 1'b1;
        ctl.lane.load = 1'b1;
      end
      tdsp_pkg::ST_SCALE: begin
        ctl.lane.step = 1'b1;
      end
      tdsp_pkg::ST_FINISH: begin
        ctl.finish = !out_busy;
      end
      default: ;
    endcase
  end

endmodule

/* sv/tank_drive_smoothing_servo_pulse.sv */
// ----------------------------------------------------------------------------
// tank_drive_smoothing_servo_pulse: tank mix, smoothing, sleep/wake, pulses
// One item at a time, with two 16-step bit-serial multiply passes per item;
// in_stall holds off a new item until the output register takes the result.
// Reset: levels 0, both channels awake, registers at defaults, no result.
// ----------------------------------------------------------------------------
module tank_drive_smoothing_servo_pulse (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input items
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [tdsp_pkg::LVL_W-1:0]    in_throttle,
  input  logic signed [tdsp_pkg::LVL_W-1:0]    in_turn,
  input  logic signed [tdsp_pkg::LVL_W-1:0]    in_dome_target,
  // result items
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [tdsp_pkg::PULSE_W-1:0]         out_left_pulse_us,
  output logic [tdsp_pkg::PULSE_W-1:0]         out_right_pulse_us,
  output logic [tdsp_pkg::PULSE_W-1:0]         out_dome_pulse_us,
  output logic                                 out_drive_enable,
  output logic                                 out_dome_enable,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tdsp_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [tdsp_pkg::CDAT_W-1:0]          cfg_data
);

  localparam int AW = tdsp_pkg::ACC_W;
  localparam int LW = tdsp_pkg::LVL_W;

  tdsp_pkg::ctl_t ctl;

  // configuration registers
  logic [tdsp_pkg::ALPHA_W-1:0]       drive_alpha_r, dome_alpha_r;
  logic [tdsp_pkg::SPAN_W-1:0]        drive_span_r, dome_span_r;
  logic signed [tdsp_pkg::TRIM_W-1:0] left_trim_r, right_trim_r;

  // state and per-item registers
  logic signed [LW-1:0] left_level_r, right_level_r, dome_level_r;
  logic                 drive_awake_r, dome_awake_r;
  logic signed [LW-1:0] tl_r, tr_r, td_r;
  logic                 out_valid_r;
  logic [tdsp_pkg::PULSE_W-1:0] left_pulse_r, right_pulse_r, dome_pulse_r;
  logic                 drive_en_r, dome_en_r;

  // mix and lane wiring
  logic signed [17:0]   t18, u18;
  logic signed [LW-1:0] tl_c, tr_c, td_c;
  logic signed [AW-1:0] op_l, op_r_lane, op_d;
  logic [tdsp_pkg::MPL_W-1:0] mpl_drive, mpl_dome;
  logic signed [AW-1:0] acc_l, acc_r_lane, acc_d;

  // settle results
  logic signed [AW-1:0] nl_raw, nr_raw, nd_raw;
  logic signed [AW-1:0] nl, nr, nd;
  logic                 drive_awake_fin, dome_awake_fin;
  logic                 drive_wake, dome_wake;

  assign cfg_ready = 1'b1;

  // configuration write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_alpha_r <= tdsp_pkg::ALPHA_RST;
      dome_alpha_r  <= tdsp_pkg::ALPHA_RST;
      drive_span_r  <= tdsp_pkg::SPAN_RST;
      dome_span_r   <= tdsp_pkg::SPAN_RST;
      left_trim_r   <= '0;
      right_trim_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tdsp_pkg::CFG_DRIVE_ALPHA: drive_alpha_r <= cfg_data;
        tdsp_pkg::CFG_DOME_ALPHA:  dome_alpha_r  <= cfg_data;
        tdsp_pkg::CFG_DRIVE_SPAN:  drive_span_r  <= cfg_data[tdsp_pkg::SPAN_W-1:0];
        tdsp_pkg::CFG_DOME_SPAN:   dome_span_r   <= cfg_data[tdsp_pkg::SPAN_W-1:0];
        tdsp_pkg::CFG_LEFT_TRIM:   left_trim_r   <= cfg_data[tdsp_pkg::TRIM_W-1:0];
        tdsp_pkg::CFG_RIGHT_TRIM:  right_trim_r  <= cfg_data[tdsp_pkg::TRIM_W-1:0];
        default: ;
      endcase
    end
  end

  // tank mix with saturation to +/-1.0
  always_comb begin
    t18  = {{2{in_throttle[LW-1]}}, in_throttle};
    u18  = {{2{in_turn[LW-1]}}, in_turn};
    tl_c = tdsp_pkg::sat_q14(t18 + u18);
    tr_c = tdsp_pkg::sat_q14(t18 - u18);
    td_c = tdsp_pkg::sat_q14({{2{in_dome_target[LW-1]}}, in_dome_target});
  end

  // wake tests on the targets of this item
  assign drive_wake = (tdsp_pkg::mag19(tdsp_pkg::ext19(tl_r)) >= tdsp_pkg::WAKE_MIN) ||
                      (tdsp_pkg::mag19(tdsp_pkg::ext19(tr_r)) >= tdsp_pkg::WAKE_MIN);
  assign dome_wake  = (tdsp_pkg::mag19(tdsp_pkg::ext19(td_r)) >= tdsp_pkg::WAKE_MIN);

  // new levels: level plus rounded step, snap, then sleep/wake gating
  always_comb begin
    nl_raw = tdsp_pkg::ext19(left_level_r) + acc_l;
    nr_raw = tdsp_pkg::ext19(right_level_r) + acc_r_lane;
    nd_raw = tdsp_pkg::ext19(dome_level_r) + acc_d;
    nl = (tdsp_pkg::mag19(nl_raw) <= tdsp_pkg::DRIVE_SNAP_MAX) ? '0 : nl_raw;
    nr = (tdsp_pkg::mag19(nr_raw) <= tdsp_pkg::DRIVE_SNAP_MAX) ? '0 : nr_raw;
    nd = (tdsp_pkg::mag19(nd_raw) <= tdsp_pkg::DOME_SNAP_MAX)  ? '0 : nd_raw;

    drive_awake_fin = drive_awake_r;
    if (nl == '0 && nr == '0) begin
      drive_awake_fin = 1'b0;
    end else if (!drive_awake_r) begin
      if (drive_wake) begin
        drive_awake_fin = 1'b1;
      end else begin
        nl = '0;
        nr = '0;
      end
    end

    dome_awake_fin = dome_awake_r;
    if (nd == '0) begin
      dome_awake_fin = 1'b0;
    end else if (!dome_awake_r) begin
      if (dome_wake) begin
        dome_awake_fin = 1'b1;
      end else begin
        nd = '0;
      end
    end
  end

  // lane operands: target minus level for smoothing, magnitude for scaling
  always_comb begin
    if (ctl.settle) begin
      op_l      = tdsp_pkg::mag19(nl);
      op_r_lane = tdsp_pkg::mag19(nr);
      op_d      = tdsp_pkg::mag19(nd);
      mpl_drive = {4'b0000, drive_span_r, 2'b00};
      mpl_dome  = {4'b0000, dome_span_r, 2'b00};
    end else begin
      op_l      = tdsp_pkg::ext19(tl_c) - tdsp_pkg::ext19(left_level_r);
      op_r_lane = tdsp_pkg::ext19(tr_c) - tdsp_pkg::ext19(right_level_r);
      op_d      = tdsp_pkg::ext19(td_c) - tdsp_pkg::ext19(dome_level_r);
      mpl_drive = drive_alpha_r;
      mpl_dome  = dome_alpha_r;
    end
  end

  // levels and awake flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_level_r  <= '0;
      right_level_r <= '0;
      dome_level_r  <= '0;
      drive_awake_r <= 1'b1;
      dome_awake_r  <= 1'b1;
    end else if (ctl.settle) begin
      left_level_r  <= nl[LW-1:0];
      right_level_r <= nr[LW-1:0];
      dome_level_r  <= nd[LW-1:0];
      drive_awake_r <= drive_awake_fin;
      dome_awake_r  <= dome_awake_fin;
    end
  end

  // targets held for the wake test
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      tl_r <= tl_c;
      tr_r <= tr_c;
      td_r <= td_c;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      left_pulse_r  <= drive_awake_r ?
                       tdsp_pkg::pulse_calc(left_trim_r, acc_l[tdsp_pkg::Q_W-1:0],
                                            left_level_r[LW-1]) :
                       tdsp_pkg::PULSE_CENTER;
      right_pulse_r <= drive_awake_r ?
                       tdsp_pkg::pulse_calc(right_trim_r, acc_r_lane[tdsp_pkg::Q_W-1:0],
                                            !right_level_r[LW-1]) :
                       tdsp_pkg::PULSE_CENTER;
      dome_pulse_r  <= dome_awake_r ?
                       tdsp_pkg::pulse_calc('0, acc_d[tdsp_pkg::Q_W-1:0],
                                            dome_level_r[LW-1]) :
                       tdsp_pkg::PULSE_CENTER;
      drive_en_r    <= drive_awake_r;
      dome_en_r     <= dome_awake_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_left_pulse_us  = left_pulse_r;
  assign out_right_pulse_us = right_pulse_r;
  assign out_dome_pulse_us  = dome_pulse_r;
  assign out_drive_enable   = drive_en_r;
  assign out_dome_enable    = dome_en_r;

  // sequencer
  tdsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_busy (out_valid_r && out_stall),
    .in_stall (in_stall),
    .ctl      (ctl)
  );

  // serial multiply lanes: left, right, dome
  tdsp_mac_lane u_lane_left (
    .clk     (clk),
    .ctl     (ctl.lane),
    .op_in   (op_l),
    .mpl_in  (mpl_drive),
    .acc_out (acc_l)
  );

  tdsp_mac_lane u_lane_right (
    .clk     (clk),
    .ctl     (ctl.lane),
    .op_in   (op_r_lane),
    .mpl_in  (mpl_drive),
    .acc_out (acc_r_lane)
  );

  tdsp_mac_lane u_lane_dome (
    .clk     (clk),
    .ctl     (ctl.lane),
    .op_in   (op_d),
    .mpl_in  (mpl_dome),
    .acc_out (acc_d)
  );

`ifndef NO_ASSERTIONS
  // an accepted item blocks further input until it is done
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while an item is in progress");

  // a sleeping drive pair holds both levels at zero
  a_drive_sleep_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !drive_awake_r |-> (left_level_r == '0 && right_level_r == '0))
    else $error("drive asleep with nonzero level");

  // disabled drive reports neutral pulses
  a_drive_neutral: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_drive_enable) |->
      (out_left_pulse_us == tdsp_pkg::PULSE_CENTER &&
       out_right_pulse_us == tdsp_pkg::PULSE_CENTER))
    else $error("drive pulses not neutral while asleep");

  // disabled dome reports a neutral pulse
  a_dome_neutral: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_dome_enable) |-> out_dome_pulse_us == tdsp_pkg::PULSE_CENTER)
    else $error("dome pulse not neutral while asleep");

  // every delivered pulse lies within the servo range
  a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_left_pulse_us >= tdsp_pkg::PULSE_MIN && out_left_pulse_us <= tdsp_pkg::PULSE_MAX &&
       out_right_pulse_us >= tdsp_pkg::PULSE_MIN && out_right_pulse_us <= tdsp_pkg::PULSE_MAX &&
       out_dome_pulse_us >= tdsp_pkg::PULSE_MIN && out_dome_pulse_us <= tdsp_pkg::PULSE_MAX))
    else $error("pulse out of range");
`endif

endmodule
